>>> design/i2c_register_access_sequencer_defines.svh
// Assertion macros shared by the register access sequencer
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_DEFINES_SVH

// Check on every clock edge outside reset
`define I2CRAS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included
`define I2CRAS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/i2cras_pkg.sv
// Types, codes and constants of the register access sequencer
`timescale 1ns / 1ps

package i2cras_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_BURST = 2'd2,
        ACT_EVENT = 2'd3
    } action_t;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_START     = 8'b0000_0010,
        PH_SLA_W     = 8'b0000_0100,
        PH_REG       = 8'b0000_1000,
        PH_WDATA     = 8'b0001_0000,
        PH_REP_START = 8'b0010_0000,
        PH_SLA_R     = 8'b0100_0000,
        PH_READ      = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_TX    = 3'd3,
        CMD_RXACK = 3'd4,
        CMD_RXNAK = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_START     = 4'd1,
        ERR_REP_START = 4'd2,
        ERR_ADDR_WR   = 4'd3,
        ERR_WR_DATA   = 4'd4,
        ERR_ADDR_RD   = 4'd5,
        ERR_RD_ACK    = 4'd6,
        ERR_RD_NACK   = 4'd7,
        ERR_BAD_LEN   = 4'd8,
        ERR_BUSY      = 4'd9
    } err_t;

    localparam logic [7:0] STATUS_MASK  = 8'hF8;
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLA_R_ACK = 8'h40;
    localparam logic [7:0] ST_RD_ACK    = 8'h50;
    localparam logic [7:0] ST_RD_NACK   = 8'h58;
    localparam logic       READ_BIT     = 1'b1;

    typedef struct packed {
        action_t    action;
        logic [6:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] length;
        logic [7:0] bus_status;
        logic [7:0] bus_data;
    } item_t;

    typedef struct packed {
        phase_t     phase;
        action_t    mode;
        logic [6:0] target_address;
        logic [7:0] register_address;
        logic [7:0] pending_data;
        logic [7:0] bytes_left;
    } state_t;

    typedef struct packed {
        cmd_t       bus_command;
        logic [7:0] tx_byte;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       done_res;
        err_t       error_code;
    } result_t;

endpackage

>>> design/i2cras_if.sv
// Request and response channel interfaces of the register access sequencer
`timescale 1ns / 1ps

interface i2cras_req_if;
    import i2cras_pkg::*;

    logic       valid;
    logic       ready;
    action_t    action;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] length;
    logic [7:0] bus_status;
    logic [7:0] bus_data;

    modport source (
        output valid, action, dev_addr, reg_addr, write_data, length,
               bus_status, bus_data,
        input  ready
    );
    modport sink (
        input  valid, action, dev_addr, reg_addr, write_data, length,
               bus_status, bus_data,
        output ready
    );
endinterface

interface i2cras_rsp_if;
    import i2cras_pkg::*;

    logic       valid;
    logic       ready;
    cmd_t       bus_command;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    err_t       error_code;

    modport source (
        output valid, bus_command, tx_byte, rx_byte, rx_valid, done_res, error_code,
        input  ready
    );
    modport sink (
        input  valid, bus_command, tx_byte, rx_byte, rx_valid, done_res, error_code,
        output ready
    );
endinterface

>>> design/i2c_register_access_sequencer.sv
// Top level of the I2C register access sequencer
//
//   channel | dir | carries
//   --------+-----+--------------------------------------------------
//   req     | in  | command (write, read, burst read) or bus status beat
//   rsp     | out | bus command, byte to send, received byte, done/error
//
// One response beat per request beat. A request is registered, decoded, and its
// response lands in the output register; one beat per cycle sustained while rsp
// takes beats. The output register sets the pace: while rsp
// stalls with a beat held, the request register holds and req.ready drops.
// Reset puts the sequencer in idle with all transaction state cleared.
`timescale 1ns / 1ps
`include "i2c_register_access_sequencer_defines.svh"

module i2c_register_access_sequencer (
    input logic         clk,
    input logic         rst_n,
    i2cras_req_if.sink  req,
    i2cras_rsp_if.source rsp
);
    import i2cras_pkg::*;

    logic    in_vld_reg;
    item_t   item_reg;
    logic    out_vld_reg;
    result_t res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    item_t   req_item;
    logic    fire;
    logic    end_beat;
    logic    reading;
    logic    rsp_err;
    logic    rsp_rx;
    logic    rx_cmd;

    assign fire      = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || fire;

    assign req_item.action     = req.action;
    assign req_item.dev_addr   = req.dev_addr;
    assign req_item.reg_addr   = req.reg_addr;
    assign req_item.write_data = req.write_data;
    assign req_item.length     = req.length;
    assign req_item.bus_status = req.bus_status;
    assign req_item.bus_data   = req.bus_data;

    i2cras_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{phase: PH_IDLE, mode: ACT_WRITE, default: '0};
        end
        else
        begin
            if (req.ready)
                in_vld_reg <= req.valid;
            if (fire)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            item_reg <= req_item;
        if (fire)
            res_reg <= step_res;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.bus_command = res_reg.bus_command;
    assign rsp.tx_byte     = res_reg.tx_byte;
    assign rsp.rx_byte     = res_reg.rx_byte;
    assign rsp.rx_valid    = res_reg.rx_valid;
    assign rsp.done_res    = res_reg.done_res;
    assign rsp.error_code  = res_reg.error_code;

    // assertion terms
    assign end_beat = fire && step_res.done_res && (step_res.error_code != ERR_BUSY);
    assign reading  = (state_reg.phase == PH_READ);
    assign rsp_err  = rsp.valid && (rsp.error_code != ERR_OK);
    assign rsp_rx   = rsp.valid && rsp.rx_valid;
    assign rx_cmd   = (rsp.bus_command == CMD_RXACK) || (rsp.bus_command == CMD_RXNAK) ||
                      (rsp.bus_command == CMD_STOP);

    `I2CRAS_ASSERT(a_end_goes_idle, end_beat |=> state_reg.phase == PH_IDLE, "no return to idle")
    `I2CRAS_ASSERT(a_read_has_bytes, reading |-> state_reg.bytes_left != 8'd0, "read phase empty")
    `I2CRAS_ASSERT(a_err_is_done, rsp_err |-> rsp.done_res, "error code without done")
    `I2CRAS_ASSERT_ALWAYS(a_rx_with_read_cmd, rsp_rx |-> rx_cmd, "received byte on a non-read command")

endmodule

>>> design/i2cras_step.sv
// Next-state and bus command decode for one beat of the sequencer
`timescale 1ns / 1ps

module i2cras_step (
    input  i2cras_pkg::state_t  state,
    input  i2cras_pkg::item_t   item,
    output i2cras_pkg::state_t  state_next,
    output i2cras_pkg::result_t result
);
    import i2cras_pkg::*;

    logic [7:0] st;
    logic [7:0] sla;
    logic       last;
    logic [7:0] left_next;

    function automatic result_t mk_res(cmd_t cmd, logic [7:0] tx, logic [7:0] rx,
                                       logic rxv, logic done, err_t err);
        result_t r;
        r.bus_command = cmd;
        r.tx_byte     = tx;
        r.rx_byte     = rx;
        r.rx_valid    = rxv;
        r.done_res    = done;
        r.error_code  = err;
        return r;
    endfunction

    assign st        = item.bus_status & STATUS_MASK;
    assign sla       = {state.target_address, 1'b0};
    assign last      = (state.bytes_left <= 8'd1);
    assign left_next = last ? 8'd0 : state.bytes_left - 8'd1;

    always_comb
    begin
        state_next = state;
        result     = mk_res(CMD_NONE, 8'd0, 8'd0, 1'b0, 1'b0, ERR_OK);

        if (item.action != ACT_EVENT)
        begin
            if (state.phase != PH_IDLE)
            begin
                result = mk_res(CMD_NONE, 8'd0, 8'd0, 1'b0, 1'b1, ERR_BUSY);
            end
            else if (item.action == ACT_BURST && item.length == 8'd0)
            begin
                result = mk_res(CMD_NONE, 8'd0, 8'd0, 1'b0, 1'b1, ERR_BAD_LEN);
            end
            else
            begin
                state_next.mode             = item.action;
                state_next.target_address   = item.dev_addr;
                state_next.register_address = item.reg_addr;
                state_next.pending_data     = item.write_data;
                state_next.bytes_left       = (item.action == ACT_BURST) ? item.length :
                                              (item.action == ACT_READ)  ? 8'd1 : 8'd0;
                state_next.phase            = PH_START;
                result = mk_res(CMD_START, 8'd0, 8'd0, 1'b0, 1'b0, ERR_OK);
            end
        end
        else
        begin
            unique case (state.phase)
                PH_START:
                begin
                    if (st != ST_START)
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_START);
                    end
                    else
                    begin
                        state_next.phase = PH_SLA_W;
                        result = mk_res(CMD_TX, sla, 8'd0, 1'b0, 1'b0, ERR_OK);
                    end
                end
                PH_SLA_W:
                begin
                    if (st != ST_SLA_W_ACK)
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_ADDR_WR);
                    end
                    else
                    begin
                        state_next.phase = PH_REG;
                        result = mk_res(CMD_TX, state.register_address, 8'd0, 1'b0, 1'b0,
                                        ERR_OK);
                    end
                end
                PH_REG:
                begin
                    if (st != ST_DATA_ACK)
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_WR_DATA);
                    end
                    else if (state.mode == ACT_WRITE)
                    begin
                        state_next.phase = PH_WDATA;
                        result = mk_res(CMD_TX, state.pending_data, 8'd0, 1'b0, 1'b0,
                                        ERR_OK);
                    end
                    else
                    begin
                        state_next.phase = PH_REP_START;
                        result = mk_res(CMD_START, 8'd0, 8'd0, 1'b0, 1'b0, ERR_OK);
                    end
                end
                PH_WDATA:
                begin
                    state_next.phase = PH_IDLE;
                    if (st != ST_DATA_ACK)
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_WR_DATA);
                    else
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_OK);
                end
                PH_REP_START:
                begin
                    if (st != ST_REP_START)
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_REP_START);
                    end
                    else
                    begin
                        state_next.phase = PH_SLA_R;
                        result = mk_res(CMD_TX, {state.target_address, READ_BIT}, 8'd0,
                                        1'b0, 1'b0, ERR_OK);
                    end
                end
                PH_SLA_R:
                begin
                    if (st != ST_SLA_R_ACK)
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_ADDR_RD);
                    end
                    else if (state.bytes_left == 8'd0)
                    begin
                        // empty read list: close the transfer cleanly
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1, ERR_OK);
                    end
                    else
                    begin
                        state_next.phase = PH_READ;
                        result = mk_res((state.bytes_left == 8'd1) ? CMD_RXNAK : CMD_RXACK,
                                        8'd0, 8'd0, 1'b0, 1'b0, ERR_OK);
                    end
                end
                PH_READ:
                begin
                    if (st != (last ? ST_RD_NACK : ST_RD_ACK))
                    begin
                        state_next.phase = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, 8'd0, 1'b0, 1'b1,
                                        last ? ERR_RD_NACK : ERR_RD_ACK);
                    end
                    else if (left_next == 8'd0)
                    begin
                        state_next.bytes_left = left_next;
                        state_next.phase      = PH_IDLE;
                        result = mk_res(CMD_STOP, 8'd0, item.bus_data, 1'b1, 1'b1, ERR_OK);
                    end
                    else
                    begin
                        // ack until one byte remains, then nack it
                        state_next.bytes_left = left_next;
                        result = mk_res((left_next == 8'd1) ? CMD_RXNAK : CMD_RXACK, 8'd0,
                                        item.bus_data, 1'b1, 1'b0, ERR_OK);
                    end
                end
                default:
                begin
                    // idle: drop stray status events
                    state_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the I2C register access sequencer: predicted replies vs. rsp beats
`timescale 1ns / 1ps
module testbench;
    import i2cras_pkg::*;

    localparam int RANDOM_BEATS = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_ADDR_WR,
        SEQ_REG,
        SEQ_WDATA,
        SEQ_RESTART,
        SEQ_ADDR_RD,
        SEQ_READ
    } seq_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    i2cras_req_if req ();
    i2cras_rsp_if rsp ();

    i2c_register_access_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    item_t      pending_beats[$];
    result_t    expected_replies[$];

    // Predicted sequencer state
    seq_phase_t seq_phase  = SEQ_IDLE;
    action_t    seq_mode   = ACT_WRITE;
    logic [6:0] seq_target = '0;
    logic [7:0] seq_reg    = '0;
    logic [7:0] seq_wdata  = '0;
    logic [7:0] seq_left   = '0;

    int   total_beats  = 0;
    int   beats_in     = 0;
    int   replies_out  = 0;
    int   mismatches   = 0;
    int   closed_count = 0;
    int   error_ends   = 0;
    int   bytes_read   = 0;
    int   idle_cycles  = 0;
    logic req_took     = 1'b0;

    function automatic result_t abort_reply(err_t code);
        result_t r;
        r = '0;
        seq_phase = SEQ_IDLE;
        r.bus_command = CMD_STOP;
        r.done_res = 1'b1;
        r.error_code = code;
        return r;
    endfunction

    // Advance the predicted state by one request beat and return the reply it causes
    function automatic result_t advance_sequencer(item_t beat);
        result_t    r;
        logic [7:0] st;
        logic [7:0] sla;
        logic       is_last;
        r = '0;
        st = beat.bus_status & STATUS_MASK;
        sla = {seq_target, 1'b0};
        if (beat.action != ACT_EVENT)
        begin
            if (seq_phase != SEQ_IDLE)
            begin
                r.done_res = 1'b1;
                r.error_code = ERR_BUSY;
            end
            else if (beat.action == ACT_BURST && beat.length == 8'd0)
            begin
                r.done_res = 1'b1;
                r.error_code = ERR_BAD_LEN;
            end
            else
            begin
                seq_mode = beat.action;
                seq_target = beat.dev_addr;
                seq_reg = beat.reg_addr;
                seq_wdata = beat.write_data;
                case (beat.action)
                    ACT_BURST: seq_left = beat.length;
                    ACT_READ:  seq_left = 8'd1;
                    default:   seq_left = 8'd0;
                endcase
                seq_phase = SEQ_START;
                r.bus_command = CMD_START;
            end
        end
        else
        begin
            case (seq_phase)
                SEQ_START:
                    if (st != ST_START)
                        r = abort_reply(ERR_START);
                    else
                    begin
                        seq_phase = SEQ_ADDR_WR;
                        r.bus_command = CMD_TX;
                        r.tx_byte = sla;
                    end
                SEQ_ADDR_WR:
                    if (st != ST_SLA_W_ACK)
                        r = abort_reply(ERR_ADDR_WR);
                    else
                    begin
                        seq_phase = SEQ_REG;
                        r.bus_command = CMD_TX;
                        r.tx_byte = seq_reg;
                    end
                SEQ_REG:
                    if (st != ST_DATA_ACK)
                        r = abort_reply(ERR_WR_DATA);
                    else if (seq_mode == ACT_WRITE)
                    begin
                        seq_phase = SEQ_WDATA;
                        r.bus_command = CMD_TX;
                        r.tx_byte = seq_wdata;
                    end
                    else
                    begin
                        seq_phase = SEQ_RESTART;
                        r.bus_command = CMD_START;
                    end
                SEQ_WDATA:
                    if (st != ST_DATA_ACK)
                        r = abort_reply(ERR_WR_DATA);
                    else
                    begin
                        seq_phase = SEQ_IDLE;
                        r.bus_command = CMD_STOP;
                        r.done_res = 1'b1;
                    end
                SEQ_RESTART:
                    if (st != ST_REP_START)
                        r = abort_reply(ERR_REP_START);
                    else
                    begin
                        seq_phase = SEQ_ADDR_RD;
                        r.bus_command = CMD_TX;
                        r.tx_byte = sla | {7'd0, READ_BIT};
                    end
                SEQ_ADDR_RD:
                    if (st != ST_SLA_R_ACK)
                        r = abort_reply(ERR_ADDR_RD);
                    else if (seq_left == 8'd0)
                    begin
                        seq_phase = SEQ_IDLE;
                        r.bus_command = CMD_STOP;
                        r.done_res = 1'b1;
                    end
                    else
                    begin
                        seq_phase = SEQ_READ;
                        r.bus_command = (seq_left == 8'd1) ? CMD_RXNAK : CMD_RXACK;
                    end
                SEQ_READ:
                begin
                    is_last = (seq_left <= 8'd1);
                    if (st != (is_last ? ST_RD_NACK : ST_RD_ACK))
                        r = abort_reply(is_last ? ERR_RD_NACK : ERR_RD_ACK);
                    else
                    begin
                        seq_left = is_last ? 8'd0 : seq_left - 8'd1;
                        r.rx_byte = beat.bus_data;
                        r.rx_valid = 1'b1;
                        if (seq_left == 8'd0)
                        begin
                            seq_phase = SEQ_IDLE;
                            r.bus_command = CMD_STOP;
                            r.done_res = 1'b1;
                        end
                        else
                            r.bus_command = (seq_left == 8'd1) ? CMD_RXNAK : CMD_RXACK;
                    end
                end
                default:
                    ; // status while idle: all-zero reply
            endcase
        end
        return r;
    endfunction

    task automatic push_command(input action_t act, input logic [6:0] sla,
                                input logic [7:0] ra, input logic [7:0] wd,
                                input logic [7:0] len);
        item_t b;
        b.action = act;
        b.dev_addr = sla;
        b.reg_addr = ra;
        b.write_data = wd;
        b.length = len;
        b.bus_status = 8'($urandom_range(0, 255));
        b.bus_data = 8'($urandom_range(0, 255));
        pending_beats.push_back(b);
    endtask

    task automatic push_status(input logic [7:0] status, input logic [7:0] data);
        item_t b;
        b.action = ACT_EVENT;
        b.dev_addr = 7'($urandom_range(0, 127));
        b.reg_addr = 8'($urandom_range(0, 255));
        b.write_data = 8'($urandom_range(0, 255));
        b.length = 8'($urandom_range(0, 255));
        b.bus_status = status;
        b.bus_data = data;
        pending_beats.push_back(b);
    endtask

    function automatic logic [7:0] wrong_status(logic [7:0] code);
        logic [7:0] s;
        do
            s = 8'($urandom_range(0, 255));
        while ((s & STATUS_MASK) == code);
        return s;
    endfunction

    // Queue a command and its status beats; corrupt the status at fault_at,
    // slip a colliding command in before the status at busy_at
    task automatic queue_transaction(input action_t kind, input logic [6:0] sla,
                                     input logic [7:0] ra, input logic [7:0] wd,
                                     input int len, input int fault_at, input int busy_at);
        logic [7:0] codes[$];
        int         i;
        push_command(kind, sla, ra, wd, 8'(len));
        codes = {ST_START, ST_SLA_W_ACK, ST_DATA_ACK};
        if (kind == ACT_WRITE)
            codes.push_back(ST_DATA_ACK);
        else
        begin
            codes.push_back(ST_REP_START);
            codes.push_back(ST_SLA_R_ACK);
            for (i = 1; i < len; i++)
                codes.push_back(ST_RD_ACK);
            codes.push_back(ST_RD_NACK);
        end
        for (i = 0; i < codes.size(); i++)
        begin
            if (i == busy_at)
                push_command(action_t'($urandom_range(0, 2)), 7'($urandom_range(0, 127)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
            if (i == fault_at)
            begin
                push_status(wrong_status(codes[i]), 8'($urandom_range(0, 255)));
                break;
            end
            push_status(codes[i] | 8'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Request driver and response backpressure
    always @(negedge clk)
    begin
        item_t beat;
        int    send_idle;
        int    recv_idle;
        if (beats_in < total_beats / 3)
        begin
            send_idle = 10;
            recv_idle = 75;
        end
        else if (beats_in < 2 * total_beats / 3)
        begin
            send_idle = 75;
            recv_idle = 10;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (rst_n)
        begin
            // hold the beat until it is taken
            if (!req.valid || req_took)
            begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    beat = pending_beats.pop_front();
                    req.valid <= 1'b1;
                    req.action <= beat.action;
                    req.dev_addr <= beat.dev_addr;
                    req.reg_addr <= beat.reg_addr;
                    req.write_data <= beat.write_data;
                    req.length <= beat.length;
                    req.bus_status <= beat.bus_status;
                    req.bus_data <= beat.bus_data;
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Monitor: predict on request beats, check reply beats, watch for a hang
    always @(posedge clk)
    begin
        item_t   seen;
        result_t want;
        logic    req_fire;
        logic    rsp_fire;
        req_fire = req.valid && req.ready;
        rsp_fire = rsp.valid && rsp.ready;
        req_took <= req_fire;
        if (rst_n)
        begin
            if (req_fire)
            begin
                seen.action = req.action;
                seen.dev_addr = req.dev_addr;
                seen.reg_addr = req.reg_addr;
                seen.write_data = req.write_data;
                seen.length = req.length;
                seen.bus_status = req.bus_status;
                seen.bus_data = req.bus_data;
                expected_replies.push_back(advance_sequencer(seen));
                beats_in++;
            end
            if (rsp_fire)
            begin
                replies_out++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: reply beat with none expected: cmd=%0d tx=%02h",
                                 $realtime, rsp.bus_command, rsp.tx_byte);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.bus_command !== want.bus_command || rsp.tx_byte !== want.tx_byte ||
                        rsp.rx_byte !== want.rx_byte || rsp.rx_valid !== want.rx_valid ||
                        rsp.done_res !== want.done_res || rsp.error_code !== want.error_code)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: reply mismatch: expected cmd=%0d tx=%02h rx=%02h ",
                                      "rxv=%0d done=%0d err=%0d, got cmd=%0d tx=%02h rx=%02h ",
                                      "rxv=%0d done=%0d err=%0d"}, $realtime,
                                     want.bus_command, want.tx_byte, want.rx_byte,
                                     want.rx_valid, want.done_res, want.error_code,
                                     rsp.bus_command, rsp.tx_byte, rsp.rx_byte,
                                     rsp.rx_valid, rsp.done_res, rsp.error_code);
                    end
                    if (want.done_res)
                        closed_count++;
                    if (want.error_code != ERR_OK)
                        error_ends++;
                    if (want.rx_valid)
                        bytes_read++;
                end
            end
            if (req_fire || rsp_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int      roll;
        int      len;
        int      n_events;
        int      fault_at;
        int      busy_at;
        int      idle_noise;
        action_t kind;
        idle_noise = 0;
        req.valid = 1'b0;
        req.action = ACT_WRITE;
        req.dev_addr = '0;
        req.reg_addr = '0;
        req.write_data = '0;
        req.length = '0;
        req.bus_status = '0;
        req.bus_data = '0;
        rsp.ready = 1'b0;

        // Directed: ignored status, zero-length burst, clean write, read with a
        // colliding command, long burst broken on the first byte, failed start
        push_status(8'hFF, 8'hFF);
        push_command(ACT_BURST, 7'h7F, 8'hFF, 8'hFF, 8'd0);
        queue_transaction(ACT_WRITE, 7'h7F, 8'h00, 8'hFF, 0, -1, -1);
        queue_transaction(ACT_READ, 7'h00, 8'hFF, 8'h00, 1, -1, 1);
        queue_transaction(ACT_BURST, 7'h55, 8'hAA, 8'h00, 255, 5, -1);
        queue_transaction(ACT_WRITE, 7'h2A, 8'h55, 8'hAA, 0, 0, -1);

        // Random: mostly well-formed transactions, some broken, some noise
        while (pending_beats.size() - idle_noise < RANDOM_BEATS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                push_status(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                idle_noise++;
            end
            else if (roll < 12)
                push_command(ACT_BURST, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'd0);
            else
            begin
                roll = $urandom_range(0, 99);
                kind = (roll < 35) ? ACT_WRITE : (roll < 65) ? ACT_READ : ACT_BURST;
                roll = $urandom_range(0, 99);
                if (kind == ACT_WRITE)
                    len = 0;
                else if (kind == ACT_READ)
                    len = 1;
                else if (roll < 85)
                    len = $urandom_range(1, 6);
                else if (roll < 97)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(41, 255);
                n_events = (kind == ACT_WRITE) ? 4 : 5 + len;
                fault_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, n_events - 1) : -1;
                busy_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, n_events - 1) : -1;
                queue_transaction(kind, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), len, fault_at, busy_at);
            end
        end
        total_beats = pending_beats.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_beats.size() != 0 || req.valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d request beats under three backpressure mixes; checked %0d replies",
                 beats_in, replies_out);
        $display("%0d transactions closed, %0d with an error code, %0d register bytes read",
                 closed_count, error_ends, bytes_read);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/i2cras_pkg.sv
design/i2cras_if.sv
design/i2cras_step.sv
design/i2c_register_access_sequencer.sv
bench/testbench.sv
